@@ rtl/assert_macros.svh @@
// Assertion helpers shared by the RTL files.
// Each macro takes a label, the clock, the reset, the condition(s) and a message.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg)
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

@@ rtl/ppu_pkg.sv @@
`default_nettype none

package ppu_pkg;

   // Limits and field widths of the pattern chunk format.
   localparam int MAX_PATTERN_COUNT = 256;
   localparam int BYTE_W            = 8;
   localparam int ROW_W             = 16;
   localparam int SIZE_W            = 32;
   localparam int HEADER_W          = 40;
   localparam int PATTERN_W         = 9;
   localparam int FIELD_COUNT       = 6;
   localparam int CSR_INDEX_W       = 1;
   localparam int CSR_DATA_W        = 9;

   localparam logic [BYTE_W-1:0]    CHANNEL_COUNT_RESET = 8'd4;
   localparam logic [PATTERN_W-1:0] PATTERN_COUNT_RESET = 9'd0;

   // Register indexes of the configuration port.
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_CHANNEL_COUNT = 1'b0,
      CSR_PATTERN_COUNT = 1'b1
   } csr_index_type;

   // Result status codes.
   typedef enum logic [1:0] {
      ST_CELL  = 2'd0,
      ST_TRUNC = 2'd1,
      ST_BADCH = 2'd2,
      ST_NONE  = 2'd3
   } status_type;

   typedef struct packed {
      logic [BYTE_W-1:0]    channel_count;
      logic [PATTERN_W-1:0] pattern_count;
   } cfg_type;

   typedef struct packed {
      logic [7:0]             pattern_index;
      logic [ROW_W-1:0]       row_index;
      logic [BYTE_W-1:0]      channel_index;
      logic [BYTE_W-1:0]      note_value;
      logic [BYTE_W-1:0]      instrument_value;
      logic [BYTE_W-1:0]      effect_one;
      logic [BYTE_W-1:0]      param_one;
      logic [BYTE_W-1:0]      effect_two;
      logic [BYTE_W-1:0]      param_two;
      logic [FIELD_COUNT-1:0] present_mask;
      status_type             status;
      logic                   pattern_end;
   } result_type;

endpackage

`default_nettype wire

@@ rtl/ppu_channel_if.sv @@
`default_nettype none

// Input channel: one chunk byte per word.
interface ppu_req_if;
   import ppu_pkg::*;
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] data_byte;
   logic              chunk_start;

   modport source (output valid, data_byte, chunk_start, input ready);
   modport sink   (input valid, data_byte, chunk_start, output ready);
endinterface

// Result channel: one decoded cell or pattern event per word.
interface ppu_rsp_if;
   import ppu_pkg::*;
   logic                   valid;
   logic                   ready;
   logic [7:0]             pattern_index;
   logic [ROW_W-1:0]       row_index;
   logic [BYTE_W-1:0]      channel_index;
   logic [BYTE_W-1:0]      note_value;
   logic [BYTE_W-1:0]      instrument_value;
   logic [BYTE_W-1:0]      effect_one;
   logic [BYTE_W-1:0]      param_one;
   logic [BYTE_W-1:0]      effect_two;
   logic [BYTE_W-1:0]      param_two;
   logic [FIELD_COUNT-1:0] present_mask;
   logic [1:0]             status;
   logic                   pattern_end;

   modport source (output valid, pattern_index, row_index, channel_index, note_value,
                   instrument_value, effect_one, param_one, effect_two, param_two,
                   present_mask, status, pattern_end, input ready);
   modport sink   (input valid, pattern_index, row_index, channel_index, note_value,
                   instrument_value, effect_one, param_one, effect_two, param_two,
                   present_mask, status, pattern_end, output ready);
endinterface

`default_nettype wire

@@ rtl/packed_pattern_unpacker.sv @@
// A result word is registered and appears in the cycle after the byte that causes it is accepted.
// Throughput: one byte per cycle; the single output register lets a new byte in
// whenever it is empty or its word is taken in the same cycle.
// Reset (synchronous, active high) clears the parser and the output register and
// loads channel_count = 4 and pattern_count = 0.
`default_nettype none

`include "assert_macros.svh"

module packed_pattern_unpacker (
   input  wire logic                             clock,
   input  wire logic                             reset,
   ppu_req_if.sink                               req_chan,
   ppu_rsp_if.source                             rsp_chan,
   input  wire logic                             csr_write_en,
   input  wire logic [ppu_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  wire logic [ppu_pkg::CSR_DATA_W-1:0]   csr_write_data
);
   import ppu_pkg::*;

   cfg_type    cfg_ff;
   logic       req_ready;
   logic       req_accept;
   logic       parse_valid;
   result_type parse_result;
   logic       parse_error;
   logic       rsp_valid_ff;
   result_type rsp_data_ff;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.channel_count <= CHANNEL_COUNT_RESET;
         cfg_ff.pattern_count <= PATTERN_COUNT_RESET;
      end else if (csr_write_en) begin
         case (csr_index_type'(csr_index))
            CSR_CHANNEL_COUNT: cfg_ff.channel_count <= csr_write_data[BYTE_W-1:0];
            CSR_PATTERN_COUNT: cfg_ff.pattern_count <= csr_write_data[PATTERN_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // A byte is taken when the output register is free or being drained.
   assign req_ready      = !rsp_valid_ff || rsp_chan.ready;
   assign req_accept     = req_chan.valid && req_ready;
   assign req_chan.ready = req_ready;

   ppu_parser u_parser (
      .clock         (clock),
      .reset         (reset),
      .accept        (req_accept),
      .data_byte     (req_chan.data_byte),
      .chunk_start   (req_chan.chunk_start),
      .cfg           (cfg_ff),
      .result_valid  (parse_valid),
      .result        (parse_result),
      .error_latched (parse_error)
   );

   // Output register holding one result word.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_accept) begin
         rsp_valid_ff <= parse_valid;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept && parse_valid) begin
         rsp_data_ff <= parse_result;
      end
   end

   assign rsp_chan.valid            = rsp_valid_ff;
   assign rsp_chan.pattern_index    = rsp_data_ff.pattern_index;
   assign rsp_chan.row_index        = rsp_data_ff.row_index;
   assign rsp_chan.channel_index    = rsp_data_ff.channel_index;
   assign rsp_chan.note_value       = rsp_data_ff.note_value;
   assign rsp_chan.instrument_value = rsp_data_ff.instrument_value;
   assign rsp_chan.effect_one       = rsp_data_ff.effect_one;
   assign rsp_chan.param_one        = rsp_data_ff.param_one;
   assign rsp_chan.effect_two       = rsp_data_ff.effect_two;
   assign rsp_chan.param_two        = rsp_data_ff.param_two;
   assign rsp_chan.present_mask     = rsp_data_ff.present_mask;
   assign rsp_chan.status           = rsp_data_ff.status;
   assign rsp_chan.pattern_end      = rsp_data_ff.pattern_end;

   // A bad channel word must leave the parser locked up.
   `ASSERT_NEXT(a_badch_locks, clock, reset,
      req_accept && parse_valid && parse_result.status == ST_BADCH, parse_error,
      "bad channel did not latch the error")
   // The parser stays silent while it is locked, unless a chunk restarts it.
   `ASSERT_IMPLIES(a_locked_silent, clock, reset,
      parse_error && !req_chan.chunk_start, !parse_valid,
      "locked parser produced a result")
   // A word that is not drained is never overwritten.
   `ASSERT_IMPLIES(a_no_overrun, clock, reset,
      rsp_valid_ff && !rsp_chan.ready, !req_accept,
      "byte accepted while output register was full")

endmodule

`default_nettype wire

@@ rtl/ppu_parser.sv @@
`default_nettype none

module ppu_parser (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          accept,
   input  wire logic [ppu_pkg::BYTE_W-1:0]    data_byte,
   input  wire logic                          chunk_start,
   input  wire ppu_pkg::cfg_type              cfg,
   output      logic                          result_valid,
   output      ppu_pkg::result_type           result,
   output      logic                          error_latched
);
   import ppu_pkg::*;

   typedef enum logic [3:0] {
      PH_HDR0     = 4'd0,
      PH_HDR1     = 4'd1,
      PH_HDR2     = 4'd2,
      PH_HDR3     = 4'd3,
      PH_HDR4     = 4'd4,
      PH_HDR_LAST = 4'd5,
      PH_CHAN     = 4'd6,
      PH_FLAGS    = 4'd7,
      PH_FIELD    = 4'd8,
      PH_SKIP     = 4'd9
   } phase_type;

   phase_type              phase_ff, phase_in;
   logic [HEADER_W-1:0]    header_ff, header_in;
   logic [ROW_W-1:0]       rows_ff, rows_in;
   logic [SIZE_W-1:0]      left_ff, left_in;
   logic [ROW_W-1:0]       row_ff, row_in;
   logic [PATTERN_W-1:0]   pattern_ff, pattern_in;
   logic [BYTE_W-1:0]      chan_ff, chan_in;
   logic [FIELD_COUNT-1:0] flags_ff, flags_in;
   logic [FIELD_COUNT-1:0] pend_ff, pend_in;
   logic [BYTE_W-1:0]      fields_ff [FIELD_COUNT];
   logic [BYTE_W-1:0]      fields_in [FIELD_COUNT];
   logic                   err_ff, err_in;

   logic [PATTERN_W-1:0]   pattern_cur;
   logic                   limit_hit;
   logic [FIELD_COUNT-1:0] pend_low;
   logic                   done_cell;
   logic                   bad_channel;
   logic                   emit;
   logic                   emit_cell;
   logic                   emit_end;
   status_type             emit_status;

   // Next-state logic: one byte moves the parser one step.
   always_comb begin
      phase_in    = phase_ff;
      header_in   = header_ff;
      rows_in     = rows_ff;
      left_in     = left_ff;
      row_in      = row_ff;
      pattern_in  = pattern_ff;
      chan_in     = chan_ff;
      flags_in    = flags_ff;
      pend_in     = pend_ff;
      fields_in   = fields_ff;
      err_in      = err_ff;
      done_cell   = 1'b0;
      bad_channel = 1'b0;
      emit        = 1'b0;
      emit_cell   = 1'b0;
      emit_end    = 1'b0;
      emit_status = ST_NONE;

      // A chunk start restarts the parser before the byte is taken.
      if (chunk_start) begin
         phase_in   = PH_HDR0;
         header_in  = '0;
         rows_in    = '0;
         left_in    = '0;
         row_in     = '0;
         pattern_in = '0;
         chan_in    = '0;
         flags_in   = '0;
         pend_in    = '0;
         err_in     = 1'b0;
         for (int k = 0; k < FIELD_COUNT; k++) begin
            fields_in[k] = '0;
         end
      end
      pattern_cur = pattern_in;
      limit_hit   = (pattern_in >= cfg.pattern_count) ||
                    (32'(pattern_in) >= MAX_PATTERN_COUNT);
      pend_low    = pend_in & (~pend_in + 6'd1);

      if (!err_in) begin
         if (phase_in <= PH_HDR_LAST) begin
            // Header bytes: row count, then packed size, big-endian.
            if (phase_in == PH_HDR0 && limit_hit) begin
               phase_in = PH_HDR0;
            end else if (phase_in != PH_HDR_LAST) begin
               header_in = {header_in[HEADER_W-BYTE_W-1:0], data_byte};
               phase_in  = phase_type'(phase_in + 4'd1);
            end else begin
               rows_in  = header_in[HEADER_W-1:HEADER_W-ROW_W];
               left_in  = {header_in[SIZE_W-BYTE_W-1:0], data_byte};
               row_in   = '0;
               chan_in  = '0;
               flags_in = '0;
               pend_in  = '0;
               for (int k = 0; k < FIELD_COUNT; k++) begin
                  fields_in[k] = '0;
               end
               if (left_in == '0) begin
                  emit        = 1'b1;
                  emit_end    = 1'b1;
                  emit_status = ST_NONE;
                  pattern_in  = pattern_in + 9'd1;
                  phase_in    = PH_HDR0;
               end else begin
                  phase_in = (rows_in == '0) ? PH_SKIP : PH_CHAN;
               end
            end
         end else begin
            // Packed data byte.
            left_in = left_in - 32'd1;
            if (phase_in == PH_CHAN &&
                (cfg.channel_count == '0 || row_in >= rows_in)) begin
               phase_in = PH_SKIP;
            end
            case (phase_in)
               PH_CHAN: begin
                  if (data_byte == '0) begin
                     row_in = row_in + 16'd1;
                     if (row_in >= rows_in) begin
                        phase_in = PH_SKIP;
                     end
                  end else begin
                     chan_in  = data_byte - 8'd1;
                     flags_in = '0;
                     pend_in  = '0;
                     for (int k = 0; k < FIELD_COUNT; k++) begin
                        fields_in[k] = '0;
                     end
                     if (chan_in >= cfg.channel_count) begin
                        bad_channel = 1'b1;
                        err_in      = 1'b1;
                        emit        = 1'b1;
                        emit_cell   = 1'b1;
                        emit_status = ST_BADCH;
                     end else begin
                        phase_in = PH_FLAGS;
                     end
                  end
               end
               PH_FLAGS: begin
                  flags_in = data_byte[FIELD_COUNT-1:0];
                  pend_in  = flags_in;
                  if (pend_in == '0) begin
                     done_cell = 1'b1;
                  end else begin
                     phase_in = PH_FIELD;
                  end
               end
               PH_FIELD: begin
                  // The lowest waiting flag bit takes this byte.
                  for (int k = 0; k < FIELD_COUNT; k++) begin
                     if (pend_low[k]) begin
                        fields_in[k] = data_byte;
                     end
                  end
                  pend_in = pend_in & ~pend_low;
                  if (pend_in == '0) begin
                     done_cell = 1'b1;
                  end
               end
               default: begin
                  phase_in = PH_SKIP;
               end
            endcase

            // Cell completion and end of the packed data.
            if (!bad_channel) begin
               if (done_cell) begin
                  phase_in    = PH_CHAN;
                  emit        = 1'b1;
                  emit_cell   = 1'b1;
                  emit_status = ST_CELL;
                  emit_end    = (left_in == '0);
               end else if (left_in == '0) begin
                  emit      = 1'b1;
                  emit_end  = 1'b1;
                  emit_cell = (phase_in == PH_FLAGS) || (phase_in == PH_FIELD);
                  emit_status = emit_cell ? ST_TRUNC : ST_NONE;
               end
               if (left_in == '0) begin
                  pattern_in = pattern_in + 9'd1;
                  phase_in   = PH_HDR0;
               end
            end
         end
      end
   end

   // Result word assembled from the updated cell state.
   always_comb begin
      result_valid            = emit;
      result.pattern_index    = pattern_cur[7:0];
      result.row_index        = row_in;
      result.channel_index    = emit_cell ? chan_in : '0;
      result.note_value       = emit_cell ? fields_in[0] : '0;
      result.instrument_value = emit_cell ? fields_in[1] : '0;
      result.effect_one       = emit_cell ? fields_in[2] : '0;
      result.param_one        = emit_cell ? fields_in[3] : '0;
      result.effect_two       = emit_cell ? fields_in[4] : '0;
      result.param_two        = emit_cell ? fields_in[5] : '0;
      result.present_mask     = emit_cell ? flags_in : '0;
      result.status           = emit_status;
      result.pattern_end      = emit_end;
   end

   assign error_latched = err_ff;

   // Parser state advances once per accepted byte.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_HDR0;
         header_ff  <= '0;
         rows_ff    <= '0;
         left_ff    <= '0;
         row_ff     <= '0;
         pattern_ff <= '0;
         chan_ff    <= '0;
         flags_ff   <= '0;
         pend_ff    <= '0;
         err_ff     <= 1'b0;
         for (int k = 0; k < FIELD_COUNT; k++) begin
            fields_ff[k] <= '0;
         end
      end else if (accept) begin
         phase_ff   <= phase_in;
         header_ff  <= header_in;
         rows_ff    <= rows_in;
         left_ff    <= left_in;
         row_ff     <= row_in;
         pattern_ff <= pattern_in;
         chan_ff    <= chan_in;
         flags_ff   <= flags_in;
         pend_ff    <= pend_in;
         err_ff     <= err_in;
         fields_ff  <= fields_in;
      end
   end

endmodule

`default_nettype wire
